// ----- rtl/core/bc_pkg.sv -----
// ----------------------------------------------------------------------------
// bc_pkg
// Shared widths, types and limits for the binomial coefficient block.
// ----------------------------------------------------------------------------
package bc_pkg;

  localparam int N_W        = 6;
  localparam int OUT_W      = 59;
  localparam int ACC_W      = 64;
  localparam int DIV_CNT_W  = $clog2(ACC_W);

  typedef logic [N_W-1:0]       count_t;
  typedef logic [OUT_W-1:0]     comb_t;
  typedef logic [ACC_W-1:0]     acc_t;
  typedef logic [DIV_CNT_W-1:0] div_cnt_t;

  // Largest n for which the running product is guaranteed to fit in acc_t.
  localparam count_t MAX_N = count_t'(62);

  // Status returned by the shared divider to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ----- rtl/core/bc_if.sv -----
// ----------------------------------------------------------------------------
// bc_in_if / bc_out_if
// Valid/ready channels carrying the operand pair and the coefficient.
// ----------------------------------------------------------------------------
interface bc_in_if;
  logic            valid;
  logic            ready;
  bc_pkg::count_t  n;
  bc_pkg::count_t  r;

  modport source (output valid, output n, output r, input ready);
  modport sink   (input valid, input n, input r, output ready);
endinterface

interface bc_out_if;
  logic           valid;
  logic           ready;
  bc_pkg::comb_t  combinations;

  modport source (output valid, output combinations, input ready);
  modport sink   (input valid, input combinations, output ready);
endinterface

// ----- rtl/core/bc_mul.sv -----
// ----------------------------------------------------------------------------
// bc_mul
// Shared multiplier: running value times a small six-bit factor.
// ----------------------------------------------------------------------------
module bc_mul (
  input  bc_pkg::acc_t   acc,
  input  bc_pkg::count_t factor,
  output bc_pkg::acc_t   product
);
  import bc_pkg::*;

  logic [ACC_W+N_W-1:0] full;

  // The upper bits are always zero for n up to the supported limit.
  assign full    = {{N_W{1'b0}}, acc} * {{ACC_W{1'b0}}, factor};
  assign product = full[ACC_W-1:0];

endmodule

// ----- rtl/core/bc_div.sv -----
// ----------------------------------------------------------------------------
// bc_div
// Restoring divider, one quotient bit per cycle, by a six-bit divisor.
// ----------------------------------------------------------------------------
module bc_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bc_pkg::acc_t     dividend,
  input  bc_pkg::count_t   divisor,
  output bc_pkg::acc_t     quotient,
  output bc_pkg::div_sts_t sts
);
  import bc_pkg::*;

  acc_t     quo;
  count_t   rem;
  count_t   rem_next;
  count_t   dsr;
  div_cnt_t cnt;
  logic     busy;
  logic     done;
  logic [N_W:0] trial;
  logic [N_W:0] diff;
  logic         ge;

  always_comb begin
    trial    = {rem, quo[ACC_W-1]};
    ge       = (trial >= {1'b0, dsr});
    diff     = trial - {1'b0, dsr};
    rem_next = ge ? diff[N_W-1:0] : trial[N_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= div_cnt_t'(ACC_W - 1);
      end else if (busy) begin
        cnt <= cnt - div_cnt_t'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[ACC_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = quo;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ----- rtl/core/binomial_coefficient.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient
// Computes n choose r with one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
// Usage: an operand pair (n, r) is transferred on the operands channel and
// one coefficient is later transferred on the result channel. When r is
// greater than n, or n is above 62, the result is zero.
// With k the smaller of r and n - r, the running value starts at one and
// for i = 1 .. k is multiplied by n - k + i and then divided exactly by i.
// Each step passes through the multiply state, the restoring divider and
// the collection of the quotient in the divide state. The result is
// loaded into the output register once the last step is done, and the
// next pair can be taken once that load has happened; the trivial cases
// skip the multiply and divide steps. The divider's one-bit-per-cycle
// loop sets the pace of each step.
// The operands channel is ready only while the sequencer is idle, so one
// item is worked on at a time. The result sits in an output register: a
// new pair may be taken while a finished result is still waiting, and the
// next result is held back until the receiver has taken the previous one,
// with the operands channel not ready for as long as that stall lasts.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// the result valid; no other state is kept between items.
// ----------------------------------------------------------------------------
module binomial_coefficient (
  input  logic     clk,
  input  logic     rst,
  bc_in_if.sink    operands,
  bc_out_if.source result
);
  import bc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t   state;
  acc_t     acc;
  count_t   step;
  count_t   k;
  count_t   base;
  comb_t    out_data;
  logic     out_valid;
  logic     out_load;

  // Decode of an incoming pair.
  count_t   in_diff;
  count_t   in_k;
  logic     in_zero;

  acc_t     product;
  acc_t     quotient;
  div_sts_t div_sts;
  logic     div_start;

  always_comb begin
    in_diff = operands.n - operands.r;
    in_zero = (operands.n > MAX_N) || (operands.r > operands.n);
    in_k    = (operands.r >= in_diff) ? in_diff : operands.r;
  end

  assign div_start = (state == S_MUL);

  // The finished value moves into the output register once it is free.
  assign out_load = (state == S_FIN) && (!out_valid || result.ready);

  bc_mul u_mul (
    .acc     (acc),
    .factor  (base + step),
    .product (product)
  );

  bc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (step),
    .quotient (quotient),
    .sts      (div_sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (operands.valid) begin
            k    <= in_k;
            base <= operands.n - in_k;
            step <= count_t'(1);
            if (in_zero) begin
              acc   <= '0;
              state <= S_FIN;
            end else begin
              acc   <= acc_t'(1);
              state <= (in_k == '0) ? S_FIN : S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_sts.done) begin
            acc <= quotient;
            if (step == k) begin
              state <= S_FIN;
            end else begin
              step  <= step + count_t'(1);
              state <= S_MUL;
            end
          end
        end
        S_FIN: begin
          // Load the output register once the previous result has gone.
          if (out_load) begin
            out_data <= acc[OUT_W-1:0];
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign operands.ready      = (state == S_IDLE);
  assign result.valid        = out_valid;
  assign result.combinations = out_data;

  // The divider only runs while the sequencer waits for it.
  a_div_busy_state: assert property (@(posedge clk) disable iff (rst)
    div_sts.busy |-> (state == S_DIV))
    else $error("divider busy outside the divide state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> ((step != '0) && (step <= k)))
    else $error("step index outside 1 .. k");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && !out_valid) |=> out_valid)
    else $error("finished result not loaded into the output register");

endmodule
